>>> sv/dnle_pkg.sv
`timescale 1ns / 1ps

package dnle_pkg;

	// longest label that a name may carry
	localparam int MAX_LABEL = 63;
	// label count saturates at MAX_LABEL + 1
	localparam int CNT_W  = $clog2(MAX_LABEL + 2);
	// label length and label store index
	localparam int LEN_W  = $clog2(MAX_LABEL + 1);
	localparam int ADDR_W = LEN_W;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_DASH = 8'h2D;

	// label store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_t;

	// work handed from the checker to the flush sequencer
	typedef struct packed {
		logic             flush;
		logic [LEN_W-1:0] len;
		logic             name_end;
		logic             name_bad;
	} cmd_t;

	function automatic logic char_allowed(input logic [BYTE_W-1:0] c);
		logic ok;
		ok = 1'b0;
		if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
		if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
		if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
		if (c == CHAR_DASH || c == CHAR_DOT) ok = 1'b1;
		return ok;
	endfunction

endpackage

>>> sv/dnle_in_if.sv
`timescale 1ns / 1ps

interface dnle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       in_last;

	modport source (output valid, output char_byte, output in_last, input ready);
	modport sink (input valid, input char_byte, input in_last, output ready);
endinterface

>>> sv/dnle_out_if.sv
`timescale 1ns / 1ps

interface dnle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       name_end;
	logic       name_bad;

	modport source (output valid, output out_byte, output run_last, output name_end,
		output name_bad, input ready);
	modport sink (input valid, input out_byte, input run_last, input name_end,
		input name_bad, output ready);
endinterface

>>> sv/dns_name_label_encoder.sv
`timescale 1ns / 1ps

// Encodes a dotted domain name, one character per input beat, into
// length-prefixed labels; the closing zero root byte is sent only when the
// final character flushes no label, name_end marks the final beat and
// name_bad tells whether the whole name must be dropped. Characters are
// held in a label RAM and replayed when a dot or the final character ends
// a label. An item takes one input beat; one that flushes a label stalls
// the input while it sends the length byte, then one label RAM read per
// byte through its registered read port into the output register. The
// final character of a name that flushes nothing stalls the input while
// its closing beat is sent. Items are worked one at a time.
module dns_name_label_encoder
	import dnle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	dnle_in_if.sink   char_in,
	dnle_out_if.source enc_out
);

	logic              accept;
	logic              idle;
	wr_t               wr;
	cmd_t              cmd;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	assign char_in.ready = idle;
	assign accept        = char_in.valid && idle;

	dnle_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_byte (char_in.char_byte),
		.in_last   (char_in.in_last),
		.wr        (wr),
		.cmd       (cmd)
	);

	dnle_label_ram #(
		.DATA_W (BYTE_W),
		.DEPTH  (MAX_LABEL),
		.ADDR_W (ADDR_W)
	) u_label_ram (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dnle_flush_seq u_flush_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.idle    (idle),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.enc_out (enc_out)
	);

endmodule

>>> sv/dnle_label_ram.sv
`timescale 1ns / 1ps

module dnle_label_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 63,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// registered read, data holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/dnle_checker.sv
`timescale 1ns / 1ps

module dnle_checker
	import dnle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] char_byte,
	input  logic              in_last,
	output wr_t               wr,
	output cmd_t              cmd
);

	logic [CNT_W-1:0] cnt_q;
	logic             seen_q;
	logic             err_q;

	logic             allowed;
	logic             is_dot;
	logic             cnt_zero;
	logic             cnt_over;
	logic             dot_ok;
	logic             err1;
	logic             seen1;
	logic [CNT_W-1:0] cnt1;
	logic             err2;
	logic             last_flush;

	// classify the character against the current label
	always_comb begin
		allowed  = char_allowed(char_byte);
		is_dot   = (char_byte == CHAR_DOT);
		cnt_zero = (cnt_q == '0);
		cnt_over = (cnt_q > CNT_W'(MAX_LABEL));
		dot_ok   = allowed && is_dot && !cnt_zero && !cnt_over;
		err1     = err_q || !allowed || (is_dot && !dot_ok);
		seen1    = seen_q || dot_ok;
		if (!allowed) begin
			cnt1 = cnt_q;
		end else if (is_dot) begin
			cnt1 = '0;
		end else if (!cnt_over) begin
			cnt1 = cnt_q + CNT_W'(1);
		end else begin
			cnt1 = cnt_q;
		end
		err2       = err1 || (cnt1 > CNT_W'(MAX_LABEL)) || !seen1;
		last_flush = in_last && !err2 && (cnt1 != '0);
	end

	// store label characters while within the limit
	always_comb begin
		wr.en   = accept && allowed && !is_dot && (cnt_q < CNT_W'(MAX_LABEL));
		wr.addr = cnt_q[ADDR_W-1:0];
		wr.data = char_byte;
	end

	// flush request for the sequencer
	always_comb begin
		cmd.flush    = (dot_ok && !err_q) || last_flush;
		cmd.len      = (dot_ok && !err_q) ? cnt_q[LEN_W-1:0] : cnt1[LEN_W-1:0];
		cmd.name_end = in_last;
		cmd.name_bad = in_last && err2;
	end

	// advance the name state, clear it after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			seen_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q  <= '0;
				seen_q <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				cnt_q  <= cnt1;
				seen_q <= seen1;
				err_q  <= err1;
			end
		end
	end

endmodule

>>> sv/dnle_flush_seq.sv
`timescale 1ns / 1ps

module dnle_flush_seq
	import dnle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cmd_t              cmd,
	output logic              idle,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [BYTE_W-1:0] rd_data,
	dnle_out_if.source        enc_out
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LEN  = 4'b0010,
		S_DATA = 4'b0100,
		S_ZERO = 4'b1000
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] len_q;
	logic             end_q;
	logic             bad_q;
	logic [LEN_W-1:0] iss_q;
	logic [LEN_W-1:0] mov_q;
	logic             rd_v_s1;

	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_last_q;
	logic              name_end_q;
	logic              name_bad_q;

	logic out_free;
	logic move;
	logic issue;
	logic final_mv;

	assign idle     = (state_q == S_IDLE);
	assign out_free = !out_v_q || enc_out.ready;
	assign move     = (state_q == S_DATA) && rd_v_s1 && out_free;
	assign issue    = (state_q == S_DATA) && (iss_q != len_q) && (!rd_v_s1 || move);
	assign final_mv = (mov_q == len_q - LEN_W'(1));
	assign rd_en    = issue;
	assign rd_addr  = iss_q;

	assign enc_out.valid    = out_v_q;
	assign enc_out.out_byte = out_byte_q;
	assign enc_out.run_last = run_last_q;
	assign enc_out.name_end = name_end_q;
	assign enc_out.name_bad = name_bad_q;

	// sequence the length byte, the label bytes and the closing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			end_q   <= 1'b0;
			bad_q   <= 1'b0;
			iss_q   <= '0;
			mov_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						len_q <= cmd.len;
						end_q <= cmd.name_end;
						bad_q <= cmd.name_bad;
						if (cmd.flush) state_q <= S_LEN;
						else if (cmd.name_end) state_q <= S_ZERO;
					end
				end
				S_LEN: begin
					if (out_free) begin
						iss_q   <= '0;
						mov_q   <= '0;
						state_q <= S_DATA;
					end
				end
				S_DATA: begin
					if (issue) iss_q <= iss_q + LEN_W'(1);
					if (move) begin
						mov_q <= mov_q + LEN_W'(1);
						if (final_mv) state_q <= S_IDLE;
					end
					if (issue) rd_v_s1 <= 1'b1;
					else if (move) rd_v_s1 <= 1'b0;
				end
				S_ZERO: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((state_q == S_LEN && out_free) || move || (state_q == S_ZERO && out_free)) begin
			out_v_q <= 1'b1;
		end else if (enc_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_LEN && out_free) begin
			out_byte_q <= BYTE_W'(len_q);
			run_last_q <= 1'b0;
			name_end_q <= 1'b0;
			name_bad_q <= 1'b0;
		end else if (move) begin
			out_byte_q <= rd_data;
			run_last_q <= final_mv;
			name_end_q <= final_mv && end_q;
			name_bad_q <= final_mv && end_q && bad_q;
		end else if (state_q == S_ZERO && out_free) begin
			out_byte_q <= '0;
			run_last_q <= 1'b1;
			name_end_q <= 1'b1;
			name_bad_q <= bad_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_rdv_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> state_q == S_DATA)
		else $error("read data pending outside label replay");
	a_mov_le_iss: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DATA |-> mov_q <= iss_q && iss_q <= len_q)
		else $error("replay counters out of order");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && name_end_q |-> run_last_q)
		else $error("name end on a beat that is not the last of its item");
	a_bad_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && name_bad_q |-> name_end_q)
		else $error("bad flag without name end");
`endif

endmodule

>>> verif/dns_name_label_encoder_tb.sv
`timescale 1ns / 1ps

module dns_name_label_encoder_tb;
	import dnle_pkg::*;

	localparam int RAND_ITEMS = 170;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 100;
	localparam int LIMIT_NS = 2_000_000;
	// idle odds in percent per load phase
	localparam int SEND_IDLE[3] = '{6, 50, 0};
	localparam int RECV_IDLE[3] = '{50, 6, 0};

	typedef struct {
		logic [7:0] c;
		bit         last;
	} char_beat_t;

	typedef struct {
		logic [7:0] b;
		bit         run_last;
		bit         nend;
		bit         nbad;
	} enc_beat_t;

	logic clk;
	logic arst_n;

	dnle_in_if  char_if ();
	dnle_out_if enc_if ();

	dns_name_label_encoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_if),
		.enc_out (enc_if)
	);

	char_beat_t char_q[$];
	enc_beat_t  enc_expect_q[$];
	enc_beat_t  burst_q[$];

	// shadow of the encoder state
	logic [7:0] lbl_mem [0:MAX_LABEL-1];
	logic [6:0] lbl_len;
	bit         dot_seen;
	bit         name_fail;

	int n_items;
	int in_taken;
	int err_cnt;
	int stall_at;
	int pause_at;
	int stall_left;
	bit stall_done;
	bit drain_hold;
	bit in_beat_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic log_mismatch(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic bit is_host_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == CHAR_DASH || c == CHAR_DOT;
	endfunction

	function automatic logic [7:0] rand_host_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return CHAR_DASH;
	endfunction

	function automatic int load_phase();
		if (in_taken < n_items / 3) return 0;
		if (in_taken < 2 * n_items / 3) return 1;
		return 2;
	endfunction

	// emit the current label: length byte, then its characters
	task automatic push_label();
		enc_beat_t e;
		e = '{b: 8'(lbl_len), run_last: 0, nend: 0, nbad: 0};
		burst_q.push_back(e);
		for (int i = 0; i < lbl_len; i++) begin
			e.b = lbl_mem[i];
			burst_q.push_back(e);
		end
	endtask

	// advance the shadow state by one character and queue its beats
	task automatic encode_char(input logic [7:0] c, input bit last);
		enc_beat_t e;
		burst_q = {};
		if (!is_host_char(c)) begin
			name_fail = 1;
		end else if (c == CHAR_DOT) begin
			if (lbl_len == 0 || lbl_len > MAX_LABEL) begin
				name_fail = 1;
			end else begin
				if (!name_fail) push_label();
				dot_seen = 1;
			end
			lbl_len = '0;
		end else begin
			if (lbl_len < MAX_LABEL) lbl_mem[lbl_len] = c;
			if (lbl_len < MAX_LABEL + 1) lbl_len++;
		end
		if (last) begin
			if (lbl_len > MAX_LABEL || !dot_seen) name_fail = 1;
			if (!name_fail && lbl_len != 0) push_label();
			if (burst_q.size() == 0) begin
				e = '{b: 8'h00, run_last: 0, nend: 0, nbad: 0};
				burst_q.push_back(e);
			end
			burst_q[burst_q.size()-1].nend = 1;
			burst_q[burst_q.size()-1].nbad = name_fail;
			lbl_len = '0;
			dot_seen = 0;
			name_fail = 0;
		end
		if (burst_q.size() > 0) burst_q[burst_q.size()-1].run_last = 1;
		foreach (burst_q[i]) enc_expect_q.push_back(burst_q[i]);
	endtask

	task automatic add_char(input logic [7:0] c, input bit last);
		char_beat_t cb;
		cb.c = c;
		cb.last = last;
		char_q.push_back(cb);
	endtask

	task automatic add_text(input string s, input bit end_name);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], end_name && i == s.len() - 1);
	endtask

	// mostly well-formed names; long_len > 0 forces one long clean label
	task automatic add_random_name(input int long_len, input bit long_first);
		int nlab;
		int len;
		int long_idx;
		bit dotless;
		logic [7:0] c;
		nlab = $urandom_range(1, 3);
		dotless = ($urandom_range(0, 9) == 0) && long_len == 0;
		if (dotless) nlab = 1;
		if (long_len > 0 && nlab == 1) nlab = 2;
		long_idx = long_first ? 0 : nlab - 1;
		for (int li = 0; li < nlab; li++) begin
			len = (long_len > 0 && li == long_idx) ? long_len : $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				if (len <= 6 && $urandom_range(0, 24) == 0)
					c = 8'($urandom_range(0, 255));
				else
					c = rand_host_char();
				add_char(c, 0);
			end
			if (li < nlab - 1) begin
				add_char(CHAR_DOT, 0);
				// occasional empty label
				if ($urandom_range(0, 19) == 0) add_char(CHAR_DOT, 0);
			end
		end
		if (!dotless && $urandom_range(0, 3) == 0) add_char(CHAR_DOT, 0);
		char_q[char_q.size()-1].last = 1;
	endtask

	// accept side of the input channel: predict on every beat
	always @(posedge clk) begin : take_char
		if (arst_n && char_if.valid && char_if.ready) begin
			encode_char(char_if.char_byte, char_if.in_last);
			void'(char_q.pop_front());
			in_taken++;
			in_beat_done = 1;
			if (in_taken == pause_at) drain_hold = 1;
		end
	end

	// drive characters at the falling edge
	always @(negedge clk) begin : drive_chars
		bit go;
		go = 0;
		if (!arst_n) begin
			char_if.valid = 1'b0;
		end else if (!(char_if.valid && !in_beat_done)) begin
			// release the drain pause once every result is in
			if (drain_hold && enc_expect_q.size() == 0) drain_hold = 0;
			go = char_q.size() > 0 && !drain_hold &&
				$urandom_range(0, 99) >= SEND_IDLE[load_phase()];
			char_if.valid = go;
			if (go) begin
				char_if.char_byte = char_q[0].c;
				char_if.in_last = char_q[0].last;
			end
		end
		in_beat_done = 0;
	end

	// drive output ready, with one long hold-off
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			enc_if.ready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			enc_if.ready = 1'b0;
		end else if (!stall_done && in_taken >= stall_at) begin
			stall_done = 1;
			stall_left = HOLD_CYCLES - 1;
			enc_if.ready = 1'b0;
		end else begin
			enc_if.ready = $urandom_range(0, 99) >= RECV_IDLE[load_phase()];
		end
	end

	// compare each output beat with the oldest expected one
	always @(posedge clk) begin : check_enc
		enc_beat_t want;
		if (arst_n && enc_if.valid && enc_if.ready) begin
			if (enc_expect_q.size() == 0) begin
				log_mismatch($sformatf("unexpected beat byte=%02h", enc_if.out_byte));
			end else begin
				want = enc_expect_q.pop_front();
				if (enc_if.out_byte !== want.b)
					log_mismatch($sformatf("out_byte %02h, want %02h",
						enc_if.out_byte, want.b));
				if (enc_if.run_last !== want.run_last)
					log_mismatch($sformatf("run_last %b, want %b",
						enc_if.run_last, want.run_last));
				if (enc_if.name_end !== want.nend)
					log_mismatch($sformatf("name_end %b, want %b",
						enc_if.name_end, want.nend));
				if (enc_if.name_bad !== want.nbad)
					log_mismatch($sformatf("name_bad %b, want %b",
						enc_if.name_bad, want.nbad));
			end
		end
	end

	initial begin : run_stim
		int n_directed;
		int k;
		arst_n = 1'b0;
		char_if.valid = 1'b0;
		char_if.char_byte = '0;
		char_if.in_last = 1'b0;
		enc_if.ready = 1'b0;
		lbl_len = '0;
		dot_seen = 0;
		name_fail = 0;
		in_taken = 0;
		err_cnt = 0;
		stall_left = 0;
		stall_done = 0;
		drain_hold = 0;
		in_beat_done = 0;

		// directed names
		add_text("a.b", 1);
		add_text("Z9-.y.", 1);     // trailing dot
		add_text("x", 1);          // no dot
		add_text(".", 1);          // lone dot
		add_text(".a", 1);         // empty first label
		add_text("a..b", 1);       // empty middle label
		add_char("k", 0);
		add_char(8'h00, 0);        // disallowed byte mid-label
		add_text(".q", 1);
		add_text("m.", 0);
		add_char(8'hFF, 1);        // disallowed final byte
		n_directed = char_q.size();

		// random names, a few with labels at and past the length limit
		k = 0;
		while (char_q.size() - n_directed < RAND_ITEMS) begin
			case (k)
				2: add_random_name(MAX_LABEL, 0);
				5: add_random_name(MAX_LABEL + 1 + $urandom_range(0, 2), 0);
				8: add_random_name(MAX_LABEL + 1, 1);
				default: add_random_name(0, 0);
			endcase
			k++;
		end
		n_items = char_q.size();
		stall_at = 2 * n_items / 3 + 5;
		pause_at = 2 * n_items / 3 + 40;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all beats in and all results out
		while (char_q.size() != 0 || enc_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#LIMIT_NS;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
